// ===== rtl/ttcs_pkg.sv =====
// types, constants and step functions of the triangle transform, cull and shade core
// no dependencies; imported by the core and its checker
package ttcs_pkg;

  localparam int unsigned DIV_STEPS   = 32;
  localparam int unsigned SQRT_STEPS  = 31;
  localparam int unsigned SHADE_STEPS = 8;
  localparam int unsigned FRONT_STAGES = 4;
  localparam int unsigned NORM_STAGES  = 4;
  localparam int unsigned POST_STAGES  = 3;
  localparam int unsigned NUM_STAGES = FRONT_STAGES + NORM_STAGES + SQRT_STEPS + SHADE_STEPS + 1;
  localparam int unsigned PROJ_DELAY = NORM_STAGES + SQRT_STEPS + SHADE_STEPS
                                       - DIV_STEPS - POST_STAGES;

  typedef enum logic [3:0] {
    REG_ROT_ROW_0   = 4'd0,
    REG_ROT_ROW_1   = 4'd1,
    REG_ROT_ROW_2   = 4'd2,
    REG_VIEW_Z_OFS  = 4'd3,
    REG_PROJ_X      = 4'd4,
    REG_PROJ_Y      = 4'd5,
    REG_DEPTH_SCALE = 4'd6,
    REG_DEPTH_OFS   = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [17:0]        rem;
    logic [31:0]        dq;
    logic [17:0]        den;
    logic               neg;
    logic               zero;
    logic signed [20:0] fb;
  } div_t;

  typedef struct packed {
    logic        vis;
    logic [62:0] rem;
    logic [30:0] root;
    logic [30:0] a2;
  } sqrt_t;

  typedef struct packed {
    logic        vis;
    logic [38:0] rem;
    logic [30:0] mag;
    logic [7:0]  q;
  } shade_t;

  typedef struct packed {
    logic signed [11:0] x;
    logic signed [11:0] y;
    logic signed [15:0] d;
  } proj_t;

  function automatic logic signed [15:0] sat16(input logic signed [32:0] v);
    if (v > 33'sd32767) begin
      return 16'sh7fff;
    end else if (v < -33'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic logic signed [11:0] sat12(input logic signed [31:0] v);
    if (v > 32'sd2047) begin
      return 12'sh7ff;
    end else if (v < -32'sd2048) begin
      return 12'sh800;
    end
    return v[11:0];
  endfunction

  // one restoring divide step
  function automatic div_t div_step(input div_t s);
    div_t        o;
    logic [18:0] r;
    logic        b;
    o = s;
    r = {s.rem, s.dq[31]};
    b = (r >= {1'b0, s.den});
    if (b) begin
      r = r - {1'b0, s.den};
    end
    o.rem = r[17:0];
    o.dq  = {s.dq[30:0], b};
    return o;
  endfunction

  // one root bit, remainder kept as n - root^2
  function automatic sqrt_t sqrt_step(input sqrt_t s, input int unsigned b);
    sqrt_t       o;
    logic [62:0] trial;
    o = s;
    trial = (63'(s.root) << (b + 1)) + (63'(1) << (2 * b));
    if (s.rem >= trial) begin
      o.rem  = s.rem - trial;
      o.root = s.root | (31'(1) << b);
    end
    return o;
  endfunction

  function automatic shade_t shade_step(input shade_t s, input int unsigned b);
    shade_t      o;
    logic [38:0] t;
    o = s;
    t = 39'(s.mag) << b;
    if (s.rem >= t) begin
      o.rem = s.rem - t;
      o.q   = s.q | (8'(1) << b);
    end
    return o;
  endfunction

endpackage

// ===== rtl/triangle_transform_cull_shade_core.sv =====
// triangle transform, back-face cull, projection and flat shade core
// depends on ttcs_pkg
// throughput: one triangle per cycle unless a waiting output word stalls; the 32-step projection dividers and the
// 31-step square root are fully pipelined, one bit per stage
// a waiting output word holds the whole pipeline until it is taken
// reset clears all valid flags and loads the default configuration
module triangle_transform_cull_shade_core import ttcs_pkg::*; #(
  parameter int unsigned SCREEN_W = 800,
  parameter int unsigned SCREEN_H = 600
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [3:0]         cfg_index_i,
  input  logic [47:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] v0_x_i,
  input  logic signed [15:0] v0_y_i,
  input  logic signed [15:0] v0_z_i,
  input  logic signed [15:0] v1_x_i,
  input  logic signed [15:0] v1_y_i,
  input  logic signed [15:0] v1_z_i,
  input  logic signed [15:0] v2_x_i,
  input  logic signed [15:0] v2_y_i,
  input  logic signed [15:0] v2_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               visible_o,
  output logic signed [11:0] p0_x_o,
  output logic signed [11:0] p0_y_o,
  output logic signed [11:0] p1_x_o,
  output logic signed [11:0] p1_y_o,
  output logic signed [11:0] p2_x_o,
  output logic signed [11:0] p2_y_o,
  output logic signed [15:0] p0_depth_o,
  output logic signed [15:0] p1_depth_o,
  output logic signed [15:0] p2_depth_o,
  output logic [7:0]         shade_o
);

  localparam logic signed [12:0] ScreenW = 13'(SCREEN_W);
  localparam logic signed [12:0] ScreenH = 13'(SCREEN_H);

  logic [47:0]        rot_q [3];
  logic signed [15:0] vzo_q;
  logic [15:0]        xs_q;
  logic [15:0]        ys_q;
  logic [15:0]        ds_q;
  logic signed [15:0] dof_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0] <= 48'd16384;
      rot_q[1] <= 48'd16384 << 16;
      rot_q[2] <= 48'd16384 << 32;
      vzo_q    <= 16'sd12288;
      xs_q     <= 16'd12288;
      ys_q     <= 16'd16384;
      ds_q     <= 16'd16386;
      dof_q    <= -16'sd410;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ROT_ROW_0:   rot_q[0] <= cfg_wdata_i;
        REG_ROT_ROW_1:   rot_q[1] <= cfg_wdata_i;
        REG_ROT_ROW_2:   rot_q[2] <= cfg_wdata_i;
        REG_VIEW_Z_OFS:  vzo_q    <= cfg_wdata_i[15:0];
        REG_PROJ_X:      xs_q     <= cfg_wdata_i[15:0];
        REG_PROJ_Y:      ys_q     <= cfg_wdata_i[15:0];
        REG_DEPTH_SCALE: ds_q     <= cfg_wdata_i[15:0];
        REG_DEPTH_OFS:   dof_q    <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic                  en;
  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES-1:0] v_d;

  assign en         = !v_q[NUM_STAGES-1] || out_ready_i;
  assign in_ready_o = en;
  assign v_d        = {v_q[NUM_STAGES-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= v_d;
    end
  end

  // stage 1: rotation products
  logic signed [15:0] vin [9];
  logic signed [15:0] coef [3][3];
  logic signed [31:0] prod1_q [3][3][3];

  assign vin = '{v0_x_i, v0_y_i, v0_z_i, v1_x_i, v1_y_i, v1_z_i, v2_x_i, v2_y_i, v2_z_i};

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        coef[r][c] = rot_q[r][16*c +: 16];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int v = 0; v < 3; v++) begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            prod1_q[v][r][c] <= 32'(vin[3*v+c]) * 32'(coef[r][c]);
          end
        end
      end
    end
  end

  // stage 2: sum, offset, saturate
  logic signed [15:0] tv_d [3][3];
  logic signed [15:0] tv_q [3][3];

  always_comb begin
    logic signed [33:0] acc;
    logic signed [20:0] t;
    for (int v = 0; v < 3; v++) begin
      for (int r = 0; r < 3; r++) begin
        acc = 34'(prod1_q[v][r][0]) + 34'(prod1_q[v][r][1]) + 34'(prod1_q[v][r][2]);
        t   = 21'(acc >>> 14);
        if (r == 2) begin
          t = t + 21'(vzo_q);
        end
        tv_d[v][r] = sat16(33'(t));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tv_q <= tv_d;
    end
  end

  // stage 3: edges and projection products
  logic signed [16:0] e1_q [3];
  logic signed [16:0] e2_q [3];
  logic signed [32:0] num3_q [9];
  logic signed [15:0] z3_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        e1_q[r] <= 17'(tv_q[1][r]) - 17'(tv_q[0][r]);
        e2_q[r] <= 17'(tv_q[2][r]) - 17'(tv_q[0][r]);
      end
      for (int v = 0; v < 3; v++) begin
        num3_q[3*v]   <= 33'(tv_q[v][0]) * 33'($signed({1'b0, xs_q}));
        num3_q[3*v+1] <= 33'(tv_q[v][1]) * 33'($signed({1'b0, ys_q}));
        num3_q[3*v+2] <= 33'(tv_q[v][2]) * 33'($signed({1'b0, ds_q}))
                         + (33'(dof_q) <<< 14);
        z3_q[v]       <= tv_q[v][2];
      end
    end
  end

  // stage 4: cross products, divider setup
  logic signed [33:0] cp_q [6];
  div_t               div_init [9];
  div_t               div4_q [9];

  always_comb begin
    logic [16:0]        zabs;
    logic signed [32:0] num;
    logic signed [15:0] z;
    for (int l = 0; l < 9; l++) begin
      z    = z3_q[l/3];
      num  = num3_q[l];
      zabs = z[15] ? -17'(z) : 17'(z);
      div_init[l].rem  = '0;
      div_init[l].dq   = num[32] ? 32'(-num) : 32'(num);
      div_init[l].neg  = num[32] ^ z[15];
      div_init[l].zero = (z == 16'sd0);
      if ((l % 3) == 2) begin
        div_init[l].den = 18'({zabs, 2'b00});
        div_init[l].fb  = 21'(num >>> 14);
      end else begin
        div_init[l].den = 18'(zabs);
        div_init[l].fb  = 21'(num >>> 12);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cp_q[0] <= 34'(e1_q[1]) * 34'(e2_q[2]);
      cp_q[1] <= 34'(e1_q[2]) * 34'(e2_q[1]);
      cp_q[2] <= 34'(e1_q[2]) * 34'(e2_q[0]);
      cp_q[3] <= 34'(e1_q[0]) * 34'(e2_q[2]);
      cp_q[4] <= 34'(e1_q[0]) * 34'(e2_q[1]);
      cp_q[5] <= 34'(e1_q[1]) * 34'(e2_q[0]);
      div4_q  <= div_init;
    end
  end

  // projection dividers, one quotient bit per stage
  div_t div_q [9][DIV_STEPS];

  for (genvar l = 0; l < 9; l++) begin : g_lane
    always_ff @(posedge clk_i) begin
      if (en) begin
        div_q[l][0] <= div_step(div4_q[l]);
      end
    end
    for (genvar s = 1; s < DIV_STEPS; s++) begin : g_step
      always_ff @(posedge clk_i) begin
        if (en) begin
          div_q[l][s] <= div_step(div_q[l][s-1]);
        end
      end
    end
  end

  // post: sign and zero-depth select, pixel scaling, saturation
  logic signed [32:0] ndc_q [3][2];
  logic signed [15:0] d37_q [3];
  logic signed [46:0] pm_q [3][2];
  logic signed [15:0] d38_q [3];
  proj_t              pj_q [PROJ_DELAY+1][3];

  always_ff @(posedge clk_i) begin
    logic signed [32:0] val;
    if (en) begin
      for (int l = 0; l < 9; l++) begin
        if (div_q[l][DIV_STEPS-1].zero) begin
          val = 33'(div_q[l][DIV_STEPS-1].fb);
        end else if (div_q[l][DIV_STEPS-1].neg) begin
          val = -33'(div_q[l][DIV_STEPS-1].dq);
        end else begin
          val = 33'(div_q[l][DIV_STEPS-1].dq);
        end
        if ((l % 3) == 2) begin
          d37_q[l/3] <= sat16(val);
        end else begin
          ndc_q[l/3][l%3] <= val;
        end
      end
      for (int v = 0; v < 3; v++) begin
        pm_q[v][0] <= 47'(34'(ndc_q[v][0]) + 34'sd16384) * 47'(ScreenW);
        pm_q[v][1] <= 47'(34'(ndc_q[v][1]) + 34'sd16384) * 47'(ScreenH);
        d38_q[v]   <= d37_q[v];
      end
      for (int v = 0; v < 3; v++) begin
        pj_q[0][v].x <= sat12(32'(pm_q[v][0] >>> 15));
        pj_q[0][v].y <= sat12(32'(pm_q[v][1] >>> 15));
        pj_q[0][v].d <= d38_q[v];
      end
      for (int s = 1; s <= PROJ_DELAY; s++) begin
        pj_q[s] <= pj_q[s-1];
      end
    end
  end

  // normal, cull test, magnitude scaling
  logic signed [34:0] n5_q [3];
  logic               vis5_q;
  logic [30:0]        a6_d [3];
  logic [30:0]        a6_q [3];
  logic               vis6_q;
  logic [61:0]        sq7_q [3];
  logic [30:0]        a27_q;
  logic               vis7_q;
  sqrt_t              sqrt8_q;

  always_comb begin
    logic [33:0] m [3];
    logic [2:0]  k;
    for (int r = 0; r < 3; r++) begin
      m[r] = n5_q[r][34] ? 34'(-n5_q[r]) : 34'(n5_q[r]);
    end
    k = 3'd4;
    for (int kk = 4; kk >= 0; kk--) begin
      if ((m[0] >> kk) <= 34'(1 << 30) && (m[1] >> kk) <= 34'(1 << 30) &&
          (m[2] >> kk) <= 34'(1 << 30)) begin
        k = 3'(kk);
      end
    end
    for (int r = 0; r < 3; r++) begin
      a6_d[r] = 31'(m[r] >> k);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n5_q[0] <= 35'(cp_q[0]) - 35'(cp_q[1]);
      n5_q[1] <= 35'(cp_q[2]) - 35'(cp_q[3]);
      n5_q[2] <= 35'(cp_q[4]) - 35'(cp_q[5]);
      vis5_q  <= (35'(cp_q[4]) - 35'(cp_q[5])) < 35'sd0;
      a6_q    <= a6_d;
      vis6_q  <= vis5_q;
      for (int r = 0; r < 3; r++) begin
        sq7_q[r] <= 62'(a6_q[r]) * 62'(a6_q[r]);
      end
      a27_q   <= a6_q[2];
      vis7_q  <= vis6_q;
      sqrt8_q.vis  <= vis7_q;
      sqrt8_q.rem  <= 63'(sq7_q[0]) + 63'(sq7_q[1]) + 63'(sq7_q[2]);
      sqrt8_q.root <= '0;
      sqrt8_q.a2   <= a27_q;
    end
  end

  // square root, then shade divide
  sqrt_t  sqrt_q [SQRT_STEPS];
  shade_t shade_q [SHADE_STEPS];
  shade_t shade_init;

  always_comb begin
    shade_init.vis = sqrt_q[SQRT_STEPS-1].vis;
    shade_init.rem = (39'(sqrt_q[SQRT_STEPS-1].a2) << 8) - 39'(sqrt_q[SQRT_STEPS-1].a2);
    shade_init.mag = sqrt_q[SQRT_STEPS-1].root;
    shade_init.q   = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqrt_q[0]  <= sqrt_step(sqrt8_q, SQRT_STEPS - 1);
      shade_q[0] <= shade_step(shade_init, SHADE_STEPS - 1);
    end
  end

  for (genvar j = 1; j < SQRT_STEPS; j++) begin : g_sqrt
    always_ff @(posedge clk_i) begin
      if (en) begin
        sqrt_q[j] <= sqrt_step(sqrt_q[j-1], SQRT_STEPS - 1 - j);
      end
    end
  end

  for (genvar j = 1; j < SHADE_STEPS; j++) begin : g_shade
    always_ff @(posedge clk_i) begin
      if (en) begin
        shade_q[j] <= shade_step(shade_q[j-1], SHADE_STEPS - 1 - j);
      end
    end
  end

  // output register
  logic  vis_q;
  proj_t out_pj_q [3];
  logic [7:0] shade_q_out;

  always_ff @(posedge clk_i) begin
    if (en) begin
      vis_q <= shade_q[SHADE_STEPS-1].vis;
      if (shade_q[SHADE_STEPS-1].vis) begin
        out_pj_q    <= pj_q[PROJ_DELAY];
        shade_q_out <= shade_q[SHADE_STEPS-1].q;
      end else begin
        out_pj_q    <= '{default: '0};
        shade_q_out <= '0;
      end
    end
  end

  assign out_valid_o = v_q[NUM_STAGES-1];
  assign visible_o   = vis_q;
  assign p0_x_o      = out_pj_q[0].x;
  assign p0_y_o      = out_pj_q[0].y;
  assign p1_x_o      = out_pj_q[1].x;
  assign p1_y_o      = out_pj_q[1].y;
  assign p2_x_o      = out_pj_q[2].x;
  assign p2_y_o      = out_pj_q[2].y;
  assign p0_depth_o  = out_pj_q[0].d;
  assign p1_depth_o  = out_pj_q[1].d;
  assign p2_depth_o  = out_pj_q[2].d;
  assign shade_o     = shade_q_out;

endmodule

// ===== rtl/ttcs_checker.sv =====
// port-level checks for the triangle transform, cull and shade core
// depends on ttcs_pkg and the core; attached by the bind at the end
module ttcs_checker import ttcs_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               visible_o,
  input logic signed [11:0] p0_x_o,
  input logic signed [11:0] p1_x_o,
  input logic signed [11:0] p2_x_o,
  input logic signed [11:0] p0_y_o,
  input logic signed [11:0] p1_y_o,
  input logic signed [11:0] p2_y_o,
  input logic signed [15:0] p0_depth_o,
  input logic signed [15:0] p1_depth_o,
  input logic signed [15:0] p2_depth_o,
  input logic [7:0]         shade_o
);

  // culled word carries all-zero fields
  a_culled_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !visible_o) |->
      (p0_x_o == 12'sd0 && p1_x_o == 12'sd0 && p2_x_o == 12'sd0 &&
       p0_y_o == 12'sd0 && p1_y_o == 12'sd0 && p2_y_o == 12'sd0 &&
       p0_depth_o == 16'sd0 && p1_depth_o == 16'sd0 && p2_depth_o == 16'sd0 &&
       shade_o == 8'd0))
    else $error("culled word with nonzero fields");

  // input only stalls behind a waiting output word
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output back-pressure");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(visible_o) && $stable(shade_o) && $stable(p0_x_o)))
    else $error("output word changed while stalled");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind triangle_transform_cull_shade_core ttcs_checker u_ttcs_checker (.*);
